// File: rtl/core/lppo_pkg.sv
// package for the long-press power-off controller: types, constants and helpers
`timescale 1ns / 1ps

package lppo_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;
  localparam int unsigned CfgAddrWidth = 2;

  localparam logic [CfgWidth-1:0] StartupTicksReset   = CfgWidth'(250);
  localparam logic [CfgWidth-1:0] LongPressTicksReset = CfgWidth'(50);
  localparam logic [CfgWidth-1:0] OffDelayTicksReset  = CfgWidth'(20);

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_word_t;

  typedef enum logic [CfgAddrWidth-1:0] {
    RegStartupTicks   = 2'd0,
    RegLongPressTicks = 2'd1,
    RegOffDelayTicks  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    cfg_word_t startup_ticks;
    cfg_word_t long_press_ticks;
    cfg_word_t off_delay_ticks;
  } cfg_t;

  typedef struct packed {
    logic   startup_active;
    count_t startup_count;
    logic   button_released_once;
    logic   press_counting;
    count_t press_count;
    logic   request_pending;
    logic   shutting_down;
    count_t off_count;
    logic   done;
    logic   led_level;
  } state_t;

  typedef struct packed {
    logic halted;
    logic show_off_pulse;
    logic power_hold;
    logic led_on;
  } result_t;

  localparam state_t StateReset = '{
    startup_active:       1'b1,
    startup_count:        '0,
    button_released_once: 1'b0,
    press_counting:       1'b0,
    press_count:          '0,
    request_pending:      1'b0,
    shutting_down:        1'b0,
    off_count:            '0,
    done:                 1'b0,
    led_level:            1'b1
  };

  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

  // count reaches threshold, compared at a common width
  function automatic logic reached(input count_t cnt, input cfg_word_t thr);
    logic r;
    r = CmpWidth'(cnt) >= CmpWidth'(thr);
    return r;
  endfunction

endpackage

// File: rtl/core/lppo_step.sv
// per-tick update of the power-off state and the result beat
`timescale 1ns / 1ps

module lppo_step
  import lppo_pkg::*;
(
  input  state_t  state_i,
  input  cfg_t    cfg_i,
  input  logic    button_i,
  input  logic    request_i,
  output state_t  state_o,
  output result_t result_o
);

  state_t n;
  logic   start;
  logic   pulse;

  always_comb begin
    n     = state_i;
    start = 1'b0;
    pulse = 1'b0;
    if (state_i.done) begin
      result_o = '{halted: 1'b1, show_off_pulse: 1'b0, power_hold: 1'b0, led_on: 1'b0};
    end else begin
      if (request_i) n.request_pending = 1'b1;

      // release tracking first, long-press tracking after that
      if (!state_i.button_released_once) begin
        if (!button_i) n.button_released_once = 1'b1;
      end else if (!state_i.shutting_down) begin
        if (button_i && !state_i.press_counting) begin
          n.press_counting = 1'b1;
          n.press_count    = '0;
        end else if (button_i) begin
          n.press_count = sat_inc(state_i.press_count);
        end else begin
          n.press_counting = 1'b0;
        end
        if (n.press_counting && reached(n.press_count, cfg_i.long_press_ticks)) begin
          n.request_pending = 1'b1;
        end
      end

      if (n.button_released_once && n.request_pending && !state_i.shutting_down) begin
        start             = 1'b1;
        pulse             = 1'b1;
        n.shutting_down   = 1'b1;
        n.request_pending = 1'b0;
        n.led_level       = 1'b1;
        n.off_count       = '0;
      end

      if (state_i.startup_active && !n.shutting_down) begin
        if (reached(state_i.startup_count, cfg_i.startup_ticks)) begin
          n.led_level      = 1'b0;
          n.startup_active = 1'b0;
        end else begin
          n.startup_count = sat_inc(state_i.startup_count);
        end
      end

      // off timer never fires on the starting tick
      if (n.shutting_down && !start) begin
        n.off_count = sat_inc(state_i.off_count);
        if (reached(n.off_count, cfg_i.off_delay_ticks)) begin
          n.led_level = 1'b0;
          n.done      = 1'b1;
        end
      end

      result_o = '{halted: n.done, show_off_pulse: pulse, power_hold: !n.done,
                   led_on: n.led_level};
    end
    state_o = n;
  end

endmodule

// File: rtl/core/long_press_power_off_controller.sv
// top level of the long-press power-off controller
`timescale 1ns / 1ps

// a tick beat accepted at one edge shows its result beat in the next cycle
// throughput: one tick beat per cycle, input stalls only while a result beat waits unread
// the tick update is one pass through lppo_step between the state and result registers
// reset: async active low, state to power-up values, config to defaults, output empty
module long_press_power_off_controller
  import lppo_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // tick stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,   // [0] button_pressed, [1] shutdown_request
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [7:0]              m_axis_tdata,   // [0] led_on, [1] power_hold,
                                                  // [2] show_off_pulse, [3] halted
  // register writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [CfgWidth-1:0]     cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t result_d, result_q;
  logic    out_valid_q;
  logic    in_fire;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{startup_ticks: StartupTicksReset, long_press_ticks: LongPressTicksReset,
                 off_delay_ticks: OffDelayTicksReset};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        RegStartupTicks:   cfg_q.startup_ticks    <= cfg_data_i;
        RegLongPressTicks: cfg_q.long_press_ticks <= cfg_data_i;
        RegOffDelayTicks:  cfg_q.off_delay_ticks  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lppo_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .button_i  (s_axis_tdata[0]),
    .request_i (s_axis_tdata[1]),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) result_q <= result_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, result_q.halted, result_q.show_off_pulse,
                          result_q.power_hold, result_q.led_on};

  // once halted the block stays halted until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.done |=> state_q.done)
    else $error("halt state left without reset");

  // every accepted tick beat yields a result beat on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> m_axis_tvalid)
    else $error("accepted tick beat produced no result beat");

  // the notify pulse only comes on a tick that starts shutdown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && state_q.shutting_down) |=> !result_q.show_off_pulse)
    else $error("notify pulse while already shutting down");

  // power is never released before shutdown has started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !state_q.shutting_down) |=> result_q.power_hold)
    else $error("power released without a shutdown sequence");

endmodule

// File: verif/tb_long_press_power_off_controller.sv
// self-checking testbench for the long-press power-off controller tick and result streams
`timescale 1ns / 1ps

module tb_long_press_power_off_controller
  import lppo_pkg::*;
();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [CfgAddrWidth-1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic shutdown_request;
    logic button_pressed;
  } tick_t;

  typedef enum int {TrigEarlyRequest, TrigLongPress, TrigExternal} trig_e;
  typedef enum int {BootZero, BootDefault, BootMax} boot_e;
  typedef enum int {DelayZero, DelayShort, DelayMax} delay_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgAddrWidth-1:0] cfg_addr_i = '0;
  logic [CfgWidth-1:0]     cfg_data_i = '0;

  long_press_power_off_controller dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the controller: settings and tick state
  cfg_word_t boot_limit, hold_limit, delay_limit;
  logic      boot_active, released_seen, holding, req_pending;
  logic      powering_down, power_cut, led_lit;
  count_t    boot_cnt, hold_cnt, down_cnt;

  tick_t     tick_q[$];
  result_t   expected_q[$];

  int        ticks_queued = 0;
  int        ticks_done = 0;
  int        results_seen = 0;
  int        pulses_seen = 0;
  int        halted_seen = 0;
  int        cfg_writes = 0;
  int        mismatches = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_mode = 0;
  logic      hold_off = 1'b0;
  logic [31:0] cycle_cnt = '0;

  function automatic count_t count_up(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

  function automatic result_t next_outputs(input tick_t t);
    result_t r;
    logic    started;
    r = '0;
    started = 1'b0;
    if (power_cut) begin
      r.halted = 1'b1;
    end else begin
      if (t.shutdown_request) req_pending = 1'b1;
      // the press that powered the board must end before anything counts
      if (!released_seen) begin
        if (!t.button_pressed) released_seen = 1'b1;
      end else if (!powering_down) begin
        if (t.button_pressed && !holding) begin
          holding = 1'b1;
          hold_cnt = '0;
        end else if (t.button_pressed) begin
          hold_cnt = count_up(hold_cnt);
        end else begin
          holding = 1'b0;
        end
        if (holding && hold_cnt >= hold_limit) req_pending = 1'b1;
      end
      if (released_seen && req_pending && !powering_down) begin
        powering_down = 1'b1;
        req_pending = 1'b0;
        led_lit = 1'b1;
        r.show_off_pulse = 1'b1;
        down_cnt = '0;
        started = 1'b1;
      end
      if (boot_active && !powering_down) begin
        if (boot_cnt >= boot_limit) begin
          led_lit = 1'b0;
          boot_active = 1'b0;
        end else begin
          boot_cnt = count_up(boot_cnt);
        end
      end
      // off timer never finishes on the tick shutdown starts
      if (powering_down && !started) begin
        down_cnt = count_up(down_cnt);
        if (down_cnt >= delay_limit) begin
          led_lit = 1'b0;
          power_cut = 1'b1;
        end
      end
      r.led_on = led_lit;
      r.power_hold = !power_cut;
      r.halted = power_cut;
    end
    return r;
  endfunction

  // tick driver: bursts of beats with random gaps
  always @(posedge clk_i) begin
    tick_t cur;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(next_outputs(tick_t'(s_axis_tdata[1:0])));
        ticks_done++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          cur = tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, cur};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 31);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  always @(posedge clk_i) begin
    result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[3:0]);
        results_seen++;
        if (got.show_off_pulse === 1'b1) pulses_seen++;
        if (got.halted === 1'b1) halted_seen++;
        if (expected_q.size() == 0) begin
          if (mismatches < MaxReports)
            $display("unexpected result beat: led %b hold %b pulse %b halted %b",
                     got.led_on, got.power_hold, got.show_off_pulse, got.halted);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.led_on !== want.led_on || got.power_hold !== want.power_hold ||
              got.show_off_pulse !== want.show_off_pulse || got.halted !== want.halted) begin
            if (mismatches < MaxReports)
              $display("result %0d: expected led %b hold %b pulse %b halted %b, got %b %b %b %b",
                       results_seen, want.led_on, want.power_hold, want.show_off_pulse,
                       want.halted, got.led_on, got.power_hold, got.show_off_pulse,
                       got.halted);
            mismatches++;
          end
        end
      end
      if (cycle_cnt % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= cycle_cnt[2];
        endcase
      end
    end
  end

  // long receiver hold-off so the output register fills and the input stalls
  initial begin
    wait (ticks_done >= 200);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("long_press_power_off_controller regression: fail");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CfgAddrWidth-1:0] idx, input cfg_word_t val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegStartupTicks:   boot_limit = val;
      RegLongPressTicks: hold_limit = val;
      RegOffDelayTicks:  delay_limit = val;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
  endtask

  task automatic push_tick(input logic btn, input logic req);
    tick_q.push_back('{shutdown_request: req, button_pressed: btn});
    ticks_queued++;
  endtask

  task automatic push_run(input logic btn, input int n);
    for (int i = 0; i < n; i++) push_tick(btn, 1'b0);
  endtask

  task automatic push_random(input int n);
    for (int i = 0; i < n; i++) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // presses and releases with no request; every chunk ends released so holds stay short
  task automatic button_traffic(input int n);
    int stop;
    stop = ticks_queued + n;
    while (ticks_queued < stop) begin
      case ($urandom_range(0, 9))
        0: begin
          for (int i = 0; i < 8; i++) push_tick(1'($urandom_range(0, 1)), 1'b0);
          push_tick(1'b0, 1'b0);
        end
        1: begin
          push_run(1'b1, $urandom_range(100, 300));
          push_run(1'b0, $urandom_range(1, 5));
        end
        default: begin
          push_run(1'b1, $urandom_range(1, 40));
          push_run(1'b0, $urandom_range(1, 30));
        end
      endcase
    end
  endtask

  initial begin
    trig_e  trig;
    boot_e  boot;
    delay_e delay;
    int     n;
    trig = trig_e'($urandom_range(0, 2));
    boot = boot_e'($urandom_range(0, 2));
    delay = delay_e'($urandom_range(0, 2));
    if (trig == TrigEarlyRequest) delay = DelayMax;

    boot_limit = StartupTicksReset;
    hold_limit = LongPressTicksReset;
    delay_limit = OffDelayTicksReset;
    boot_active = 1'b1;
    boot_cnt = '0;
    released_seen = 1'b0;
    holding = 1'b0;
    hold_cnt = '0;
    req_pending = 1'b0;
    powering_down = 1'b0;
    down_cnt = '0;
    power_cut = 1'b0;
    led_lit = 1'b1;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    case (boot)
      BootZero: cfg_write(RegStartupTicks, '0);
      BootMax:  cfg_write(RegStartupTicks, '1);
      default: ;
    endcase
    cfg_write(RegLongPressTicks, '1);
    cfg_write(RegUnused, cfg_word_t'($urandom));

    if (trig == TrigEarlyRequest) begin
      // request while the power-on press is still held, shutdown at release
      cfg_write(RegOffDelayTicks, '1);
      push_tick(1'b1, 1'b0);
      push_tick(1'b1, 1'b1);
      push_run(1'b1, 2);
      push_tick(1'b0, 1'b0);
    end else begin
      push_run(1'b1, 3);
      push_tick(1'b0, 1'b0);
      push_run(1'b1, 5);
      push_run(1'b0, 2);
      push_tick(1'b1, 1'b0);
      push_tick(1'b0, 1'b0);
      push_run(1'b1, 2);
      push_tick(1'b0, 1'b0);
      button_traffic(850);
      wait_idle();
      cfg_write(RegStartupTicks, (boot == BootMax) ? cfg_word_t'($urandom_range(0, 400))
                                                   : cfg_word_t'($urandom));
      cfg_write(RegLongPressTicks, cfg_word_t'(500));
      button_traffic(850);
      wait_idle();
      case (delay)
        DelayZero:  cfg_write(RegOffDelayTicks, '0);
        DelayShort: cfg_write(RegOffDelayTicks, cfg_word_t'($urandom_range(1, 50)));
        default:    cfg_write(RegOffDelayTicks, '1);
      endcase
      if (trig == TrigLongPress) begin
        n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 60);
        cfg_write(RegLongPressTicks, cfg_word_t'(n));
        push_tick(1'b0, 1'b0);
        push_run(1'b1, n + 1 + $urandom_range(0, 5));
      end else begin
        push_tick(1'($urandom_range(0, 1)), 1'b1);
      end
    end

    // shutdown window, then the halted state
    if (delay == DelayMax) begin
      push_random((trig == TrigEarlyRequest) ? 1950 : 300);
      wait_idle();
      cfg_write(RegStartupTicks, cfg_word_t'($urandom));
      cfg_write(RegOffDelayTicks, '0);
    end else begin
      push_random(int'(delay_limit) + $urandom_range(2, 20));
    end
    push_random(20);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0d expected result beats never arrived", expected_q.size());
      mismatches += expected_q.size();
    end

    $display("ran %0d ticks and %0d register writes; shutdown via %s, startup %s, off delay %s",
             ticks_done, cfg_writes, trig.name(), boot.name(), delay.name());
    $display("checked %0d result beats, %0d shutdown pulses, %0d halted beats, %0d mismatches",
             results_seen, pulses_seen, halted_seen, mismatches);
    if (mismatches == 0) begin
      $display("long_press_power_off_controller regression: pass");
    end else begin
      $display("long_press_power_off_controller regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/lppo_pkg.sv
rtl/core/lppo_step.sv
rtl/core/long_press_power_off_controller.sv
verif/tb_long_press_power_off_controller.sv
